// File: hw/rtl/mae_pkg.sv
// shared types, codes and constants for the matrix arithmetic engine
package mae_pkg;

    localparam int MAX_DIM_DEF = 16;
    localparam int DIM_W       = 5;
    localparam int IDX_W       = 4;
    localparam int OP_W        = 3;
    localparam int DATA_W      = 32;
    localparam int CFG_ADDR_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A    = 3'd0,
        OP_LOAD_B    = 3'd1,
        OP_SUM       = 3'd2,
        OP_DIFF      = 3'd3,
        OP_PRODUCT   = 3'd4,
        OP_TRANSPOSE = 3'd5
    } t_op;

    localparam logic [CFG_ADDR_W-1:0] CFG_ROWS_A = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLS_A = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROWS_B = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLS_B = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic start;
        logic issue;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_load;
        logic need_read;
        logic last_k;
        logic busy;
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/mae_datapath.sv
// matrix stores, dimension registers, multiply-accumulate pipeline and result register
module mae_datapath #(
    parameter int MAX_DIM = mae_pkg::MAX_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mae_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [mae_pkg::DIM_W-1:0]           i_cfg_data,
    input  logic [mae_pkg::OP_W-1:0]            i_operation,
    input  logic [mae_pkg::IDX_W-1:0]           i_row,
    input  logic [mae_pkg::IDX_W-1:0]           i_col,
    input  logic signed [mae_pkg::DATA_W-1:0]   i_value,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [mae_pkg::DATA_W-1:0]   o_result,
    output logic                                o_ok,
    input  mae_pkg::t_cmd                       i_cmd,
    output mae_pkg::t_status                    o_status
);

    localparam int CELLS   = MAX_DIM * MAX_DIM;
    localparam int AW      = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int DIM_CAP = (MAX_DIM > 31) ? 31 : MAX_DIM;
    localparam logic [mae_pkg::DIM_W-1:0] DIM_MAX_V = DIM_CAP[mae_pkg::DIM_W-1:0];
    localparam logic [mae_pkg::DIM_W-1:0] K_ONE =
        {{(mae_pkg::DIM_W-1){1'b0}}, 1'b1};

    function automatic logic [mae_pkg::DIM_W-1:0] clamp_dim(
        input logic [mae_pkg::DIM_W-1:0] v
    );
        if (v > DIM_MAX_V) begin
            return DIM_MAX_V;
        end
        return v;
    endfunction

    function automatic logic [AW-1:0] cell_addr(
        input logic [mae_pkg::DIM_W-1:0] rr,
        input logic [mae_pkg::DIM_W-1:0] cc
    );
        int tmp;
        tmp = int'(rr) * MAX_DIM + int'(cc);
        return tmp[AW-1:0];
    endfunction

    logic [mae_pkg::DIM_W-1:0]  r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    logic [mae_pkg::DIM_W-1:0]  row_x, col_x;
    logic                       in_a, in_b, dims_same, query_ok, is_load;
    logic                       wr_a, wr_b;
    logic [AW-1:0]              wr_addr, rd_addr_a, rd_addr_b;
    logic [mae_pkg::DIM_W-1:0]  a_row, a_col, b_row, b_col;

    logic [mae_pkg::OP_W-1:0]   r_op;
    logic [mae_pkg::IDX_W-1:0]  r_row, r_col;
    logic                       r_ok;
    logic [mae_pkg::DIM_W-1:0]  r_k;

    logic [mae_pkg::DATA_W-1:0] r_mem_a [CELLS];
    logic [mae_pkg::DATA_W-1:0] r_mem_b [CELLS];
    logic [mae_pkg::DATA_W-1:0] r_rd_a, r_rd_b, r_prod, r_acc;
    logic [mae_pkg::DATA_W-1:0] mul_full;
    logic                       r_rd_vld, r_mul_vld;

    logic [mae_pkg::DATA_W-1:0] n_result;
    logic                       r_out_vld;
    logic [mae_pkg::DATA_W-1:0] r_result;
    logic                       r_res_ok;

    // dimension registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= '0;
            r_cols_a <= '0;
            r_rows_b <= '0;
            r_cols_b <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mae_pkg::CFG_ROWS_A: r_rows_a <= clamp_dim(i_cfg_data);
                mae_pkg::CFG_COLS_A: r_cols_a <= clamp_dim(i_cfg_data);
                mae_pkg::CFG_ROWS_B: r_rows_b <= clamp_dim(i_cfg_data);
                mae_pkg::CFG_COLS_B: r_cols_b <= clamp_dim(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // range and shape checks on the incoming beat
    always_comb begin
        row_x     = {1'b0, i_row};
        col_x     = {1'b0, i_col};
        in_a      = (row_x < r_rows_a) && (col_x < r_cols_a);
        in_b      = (row_x < r_rows_b) && (col_x < r_cols_b);
        dims_same = (r_rows_a == r_rows_b) && (r_cols_a == r_cols_b);
        is_load   = (i_operation == mae_pkg::OP_LOAD_A) ||
                    (i_operation == mae_pkg::OP_LOAD_B);
        case (i_operation)
            mae_pkg::OP_SUM, mae_pkg::OP_DIFF: begin
                query_ok = dims_same && in_a;
            end
            mae_pkg::OP_PRODUCT: begin
                query_ok = (r_cols_a == r_rows_b) && (row_x < r_rows_a) &&
                           (col_x < r_cols_b);
            end
            mae_pkg::OP_TRANSPOSE: begin
                query_ok = (row_x < r_cols_a) && (col_x < r_rows_a);
            end
            default: begin
                query_ok = 1'b0;
            end
        endcase
        wr_a    = i_cmd.start && (i_operation == mae_pkg::OP_LOAD_A) && in_a;
        wr_b    = i_cmd.start && (i_operation == mae_pkg::OP_LOAD_B) && in_b;
        wr_addr = cell_addr(row_x, col_x);
    end

    // captured query
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_operation;
            r_row <= i_row;
            r_col <= i_col;
            r_ok  <= query_ok;
            r_k   <= '0;
        end else if (i_cmd.issue) begin
            r_k   <= r_k + K_ONE;
        end
    end

    // read addresses
    always_comb begin
        a_row = {1'b0, r_row};
        a_col = {1'b0, r_col};
        b_row = {1'b0, r_row};
        b_col = {1'b0, r_col};
        if (r_op == mae_pkg::OP_PRODUCT) begin
            a_col = r_k;
            b_row = r_k;
        end else if (r_op == mae_pkg::OP_TRANSPOSE) begin
            a_row = {1'b0, r_col};
            a_col = {1'b0, r_row};
        end
        rd_addr_a = cell_addr(a_row, a_col);
        rd_addr_b = cell_addr(b_row, b_col);
    end

    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_mem_a[wr_addr] <= i_value;
        end
        if (i_cmd.issue) begin
            r_rd_a <= r_mem_a[rd_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            r_mem_b[wr_addr] <= i_value;
        end
        if (i_cmd.issue) begin
            r_rd_b <= r_mem_b[rd_addr_b];
        end
    end

    // multiply then accumulate, modulo 2^32
    assign mul_full = r_rd_a * r_rd_b;

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_prod <= mul_full;
        end
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_mul_vld) begin
            r_acc <= r_acc + r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_mul_vld <= 1'b0;
        end else begin
            r_rd_vld  <= i_cmd.issue;
            r_mul_vld <= r_rd_vld;
        end
    end

    always_comb begin
        case (r_op)
            mae_pkg::OP_SUM:       n_result = r_rd_a + r_rd_b;
            mae_pkg::OP_DIFF:      n_result = r_rd_a - r_rd_b;
            mae_pkg::OP_PRODUCT:   n_result = r_acc;
            mae_pkg::OP_TRANSPOSE: n_result = r_rd_a;
            default:               n_result = '0;
        endcase
        if (!r_ok) begin
            n_result = '0;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result <= n_result;
            r_res_ok <= r_ok;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_result    = r_result;
    assign o_ok        = r_res_ok;

    always_comb begin
        o_status.is_load   = is_load;
        o_status.need_read = query_ok &&
            !((i_operation == mae_pkg::OP_PRODUCT) && (r_cols_a == '0));
        o_status.last_k    = (r_op != mae_pkg::OP_PRODUCT) || ((r_k + K_ONE) == r_cols_a);
        o_status.busy      = r_rd_vld || r_mul_vld;
        o_status.out_free  = !r_out_vld || i_out_ready;
    end

endmodule

// File: hw/rtl/mae_ctrl.sv
// sequencing state machine for loads and queries
module mae_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mae_pkg::t_status i_status,
    output mae_pkg::t_cmd    o_cmd
);

    mae_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mae_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mae_pkg::ST_IDLE: begin
                if (i_valid && !i_status.is_load) begin
                    n_state = i_status.need_read ? mae_pkg::ST_ISSUE : mae_pkg::ST_DRAIN;
                end
            end
            mae_pkg::ST_ISSUE: begin
                if (i_status.last_k) begin
                    n_state = mae_pkg::ST_DRAIN;
                end
            end
            mae_pkg::ST_DRAIN: begin
                if (!i_status.busy && i_status.out_free) begin
                    n_state = mae_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mae_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready      = 1'b0;
        o_cmd.start  = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            mae_pkg::ST_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.start = i_valid;
            end
            mae_pkg::ST_ISSUE: begin
                o_cmd.issue = 1'b1;
            end
            mae_pkg::ST_DRAIN: begin
                o_cmd.finish = !i_status.busy && i_status.out_free;
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_issue_fills_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |=> i_status.busy)
        else $error("read issued but pipeline not busy");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.start && i_status.is_load) |=> (r_state == mae_pkg::ST_IDLE))
        else $error("load left idle");

    a_finish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!i_status.busy && i_status.out_free))
        else $error("result taken before pipeline drained");
`endif

endmodule

// File: hw/rtl/matrix_arithmetic_engine_unit.sv
// top level of the integer matrix add, subtract, multiply and transpose engine
// Holds matrices A and B (up to MAX_DIM by MAX_DIM, 32-bit words) whose shapes come from
// four dimension registers. A load beat writes one element, if it lies within the shape,
// and gives no result; a query beat gives one result beat with a wrapped 32-bit value and
// an ok flag. Sum, difference and transpose issue one read to each store; a product is
// walked by the single multiply-accumulate unit, one A column and one B row per cycle
// through one read port of each store. A product with cols_a zero and a query that fails
// its shape or range check issue no read and go straight to draining. A finished result
// sits in an output register, so a new beat is accepted while it waits to be taken; the
// next query then waits in its drain state until that result is taken. The stores are
// not cleared; only written entries may be queried.
module matrix_arithmetic_engine_unit #(
    parameter int MAX_DIM = mae_pkg::MAX_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mae_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [mae_pkg::DIM_W-1:0]         i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [mae_pkg::OP_W-1:0]          i_operation,
    input  logic [mae_pkg::IDX_W-1:0]         i_row,
    input  logic [mae_pkg::IDX_W-1:0]         i_col,
    input  logic signed [mae_pkg::DATA_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [mae_pkg::DATA_W-1:0] o_result,
    output logic                              o_ok
);

    mae_pkg::t_cmd    cmd;
    mae_pkg::t_status status;

    mae_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mae_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_operation (i_operation),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_result    (o_result),
        .o_ok        (o_ok),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule
